[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hw/rtl/wrsi_pkg.sv]
// ----------------------------------------------------------------------------
// Wilder RSI package
// Widths, constants and shared types of the RSI indicator and its divider.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    // Field widths.
    localparam int PERIOD_W  = 11;
    localparam int PRICE_W   = 32;
    localparam int TIME_W    = 63;
    localparam int FRAC_BITS = 16;
    localparam int SUM_W     = 42;
    localparam int AVG_W     = 48;
    localparam int COUNT_W   = 11;
    localparam int RSI_W     = 14;
    localparam int MAX_PERIOD = 1024;

    // Stream payload widths.
    localparam int FIELDS_OUT_W = RSI_W + 2 * AVG_W + COUNT_W + 2 * SUM_W + PRICE_W + TIME_W;
    localparam int M_TDATA_W    = ((FIELDS_OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = M_TDATA_W - FIELDS_OUT_W;
    localparam int S_TDATA_W    = (((PRICE_W + TIME_W) + 7) / 8) * 8;
    localparam int IN_PAD_W     = S_TDATA_W - PRICE_W - TIME_W;

    // Divider geometry: the dividend register holds the RSI product, the widest one.
    localparam int DIV_NUM_W = AVG_W + RSI_W;
    localparam int DIV_DEN_W = AVG_W + 1;
    localparam int DIV_CNT_W = 6;

    typedef logic [DIV_NUM_W-1:0] t_div_num;
    typedef logic [DIV_DEN_W-1:0] t_div_den;
    typedef logic [AVG_W-1:0]     t_avg;

    // Typed constants.
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = PERIOD_W'(14);
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX   = PERIOD_W'(MAX_PERIOD);
    localparam logic [PERIOD_W-1:0]  PERIOD_MIN   = PERIOD_W'(1);
    localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX      = '1;
    localparam logic [AVG_W-1:0]     AVG_MAX      = '1;
    localparam logic [RSI_W-1:0]     RSI_SCALE    = RSI_W'(10000);
    localparam logic [RSI_W-1:0]     RSI_FULL     = RSI_W'(10000);
    localparam logic [DIV_CNT_W-1:0] SEED_STEPS   = DIV_CNT_W'(SUM_W + FRAC_BITS);
    localparam logic [DIV_CNT_W-1:0] WILD_STEPS   = DIV_CNT_W'(AVG_W);
    localparam logic [DIV_CNT_W-1:0] RSI_STEPS    = DIV_CNT_W'(RSI_W);

    // Divider request and status.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/wrsi_div.sv]
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Takes one quotient bit per cycle from the top of a dividend shift register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrsi_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wrsi_pkg::t_div_ctl   i_ctl,
    input  wrsi_pkg::t_div_den   i_rem_init,  // must be below i_den
    input  wrsi_pkg::t_div_num   i_num,       // bits to divide sit at the top, zeros below
    input  wrsi_pkg::t_div_den   i_den,
    output wrsi_pkg::t_div_stat  o_stat,
    output wrsi_pkg::t_div_num   o_quo,
    output wrsi_pkg::t_div_den   o_rem
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [wrsi_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    wrsi_pkg::t_div_num             r_num, n_num;
    wrsi_pkg::t_div_den             r_rem, n_rem;
    wrsi_pkg::t_div_den             r_den, n_den;
    logic [wrsi_pkg::DIV_DEN_W+1:0] trial;
    logic                           fits;

    // One restoring step: shift the next dividend bit into the remainder and try the divisor.
    assign trial = {1'b0, r_rem, r_num[wrsi_pkg::DIV_NUM_W-1]} - {2'b00, r_den};
    assign fits  = ~trial[wrsi_pkg::DIV_DEN_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = i_ctl.steps;
            n_num  = i_num;
            n_rem  = i_rem_init;
            n_den  = i_den;
        end else if (r_busy) begin
            n_num = {r_num[wrsi_pkg::DIV_NUM_W-2:0], fits};
            n_rem = fits ? trial[wrsi_pkg::DIV_DEN_W-1:0]
                         : {r_rem[wrsi_pkg::DIV_DEN_W-2:0], r_num[wrsi_pkg::DIV_NUM_W-1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == wrsi_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_num;
    assign o_rem       = r_rem;

    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n, i_ctl.start && r_busy)
    `ASSERT_PROP(a_rem_below_den, i_clk, i_rst_n, r_busy |-> (r_rem < r_den))
    `ASSERT_PROP(a_done_on_finish, i_clk, i_rst_n, $fell(r_busy) |-> r_done)

endmodule

[hw/rtl/wilder_rsi_indicator_unit.sv]
// ----------------------------------------------------------------------------
// Wilder RSI indicator unit
// Relative strength index over final price bars with Wilder smoothing.
// ----------------------------------------------------------------------------
// Usage
//   Bars enter on the s_axis channel: tdata holds close price and start time,
//   tuser holds the final flag. Results leave on m_axis: tdata holds the RSI,
//   the smoothed averages, the warm-up count and sums and the echoed bar,
//   tuser holds the seeded flag. The period register is written over the
//   cfg channel; the user must do so only while the unit is idle, as the
//   unit itself does not enforce it. One bar is processed at a time.
//   A dropped bar (not final, or not newer) or the first bar only passes
//   the filter; a warm-up bar also adds to the sums. A smoothed bar and the
//   seeding bar go through the bit-serial divider (one quotient bit per
//   cycle, 48 bits for smoothing, 58 for seeding), a 14-step shift-add
//   multiply by 10000 and a 14-bit RSI division, which is skipped when
//   the average loss is zero.
//   Results sit in an output register; a new bar is accepted while the last
//   result waits. If the receiver stalls, the next result waits inside the
//   unit until the register frees.
//   Reset clears all indicator state and sets the period to 14.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wilder_rsi_indicator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Period register write.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wrsi_pkg::PERIOD_W-1:0]  i_cfg_data,
    // Bar input.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [wrsi_pkg::S_TDATA_W-1:0] s_axis_tdata,  // close_price, start_time, pad
    input  logic [0:0]                     s_axis_tuser,  // is_final
    // Result output.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // rsi_hundredths, average_gain, average_loss, warmup_done, gain_total,
    // loss_total, close_echo, time_echo, pad
    output logic [wrsi_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                     m_axis_tuser   // seeded
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_EVAL = 10'b0000000010,
        S_ACC  = 10'b0000000100,
        S_CHK  = 10'b0000001000,
        S_SEED = 10'b0000010000,
        S_WILD = 10'b0000100000,
        S_MUL  = 10'b0001000000,
        S_RGO  = 10'b0010000000,
        S_RDIV = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    t_state                          r_state, n_state;
    logic [wrsi_pkg::PERIOD_W-1:0]   r_period, n_period;
    logic                            r_primed, n_primed;
    logic                            r_running, n_running;
    logic [wrsi_pkg::PRICE_W-1:0]    r_last_close, n_last_close;
    logic [wrsi_pkg::TIME_W-1:0]     r_last_time, n_last_time;
    logic [wrsi_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [wrsi_pkg::SUM_W-1:0]      r_sum_up, n_sum_up;
    logic [wrsi_pkg::SUM_W-1:0]      r_sum_dn, n_sum_dn;
    wrsi_pkg::t_avg                  r_avg_up, n_avg_up;
    wrsi_pkg::t_avg                  r_avg_dn, n_avg_dn;
    logic                            r_out_valid, n_out_valid;

    logic [wrsi_pkg::PRICE_W-1:0]    r_close, n_close;
    logic [wrsi_pkg::TIME_W-1:0]     r_time, n_time;
    logic                            r_final, n_final;
    logic [wrsi_pkg::PRICE_W-1:0]    r_gain, n_gain;
    logic [wrsi_pkg::PRICE_W-1:0]    r_loss, n_loss;
    logic [wrsi_pkg::PERIOD_W-1:0]   r_p, n_p;
    logic                            r_ge_up, n_ge_up;
    logic                            r_ge_dn, n_ge_dn;
    wrsi_pkg::t_div_num              r_mul_acc, n_mul_acc;
    logic [3:0]                      r_mul_cnt, n_mul_cnt;
    logic [wrsi_pkg::RSI_W-1:0]      r_rsi, n_rsi;
    logic [wrsi_pkg::M_TDATA_W-1:0]  r_out_data, n_out_data;
    logic                            r_out_user, n_out_user;

    logic [wrsi_pkg::SUM_W:0]        sum_up_x, sum_dn_x;
    logic [wrsi_pkg::COUNT_W-1:0]    count_inc;
    wrsi_pkg::t_avg                  g_up, g_dn;
    logic                            emit_load;
    wrsi_pkg::t_div_ctl              div_ctl;
    wrsi_pkg::t_div_den              div_rem, div_den;
    wrsi_pkg::t_div_num              div_num_up, div_num_dn;
    wrsi_pkg::t_div_stat             div_up_stat, div_dn_stat;
    wrsi_pkg::t_div_num              div_up_quo, div_dn_quo;
    wrsi_pkg::t_div_den              div_up_rem, div_dn_rem;
    logic [wrsi_pkg::COUNT_W-1:0]    out_count;
    logic [wrsi_pkg::SUM_W-1:0]      out_sum_up, out_sum_dn;
    wrsi_pkg::t_avg                  out_avg_up, out_avg_dn;
    logic [wrsi_pkg::RSI_W-1:0]      out_rsi;

    // Saturating warm-up sums and count.
    assign sum_up_x  = {1'b0, r_sum_up}
                     + {{(wrsi_pkg::SUM_W + 1 - wrsi_pkg::PRICE_W){1'b0}}, r_gain};
    assign sum_dn_x  = {1'b0, r_sum_dn}
                     + {{(wrsi_pkg::SUM_W + 1 - wrsi_pkg::PRICE_W){1'b0}}, r_loss};
    assign count_inc = (r_count == wrsi_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;

    // The change in Q32.16.
    assign g_up = {r_gain, {wrsi_pkg::FRAC_BITS{1'b0}}};
    assign g_dn = {r_loss, {wrsi_pkg::FRAC_BITS{1'b0}}};

    // Result fields: averages once running, warm-up sums before.
    assign out_rsi    = r_running ? r_rsi : '0;
    assign out_avg_up = r_running ? r_avg_up : '0;
    assign out_avg_dn = r_running ? r_avg_dn : '0;
    assign out_count  = r_running ? '0 : r_count;
    assign out_sum_up = r_running ? '0 : r_sum_up;
    assign out_sum_dn = r_running ? '0 : r_sum_dn;

    assign emit_load = (r_state == S_EMIT) && (!r_out_valid || m_axis_tready);

    // Sequencer and datapath.
    always_comb begin
        n_state      = r_state;
        n_period     = r_period;
        n_primed     = r_primed;
        n_running    = r_running;
        n_last_close = r_last_close;
        n_last_time  = r_last_time;
        n_count      = r_count;
        n_sum_up     = r_sum_up;
        n_sum_dn     = r_sum_dn;
        n_avg_up     = r_avg_up;
        n_avg_dn     = r_avg_dn;
        n_close      = r_close;
        n_time       = r_time;
        n_final      = r_final;
        n_gain       = r_gain;
        n_loss       = r_loss;
        n_p          = r_p;
        n_ge_up      = r_ge_up;
        n_ge_dn      = r_ge_dn;
        n_mul_acc    = r_mul_acc;
        n_mul_cnt    = r_mul_cnt;
        n_rsi        = r_rsi;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_valid  = r_out_valid && !m_axis_tready;
        div_ctl      = '0;
        div_rem      = '0;
        div_den      = wrsi_pkg::t_div_den'(r_p);
        div_num_up   = '0;
        div_num_dn   = '0;

        if (i_cfg_valid) begin
            n_period = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_close = s_axis_tdata[wrsi_pkg::PRICE_W-1:0];
                    n_time  = s_axis_tdata[wrsi_pkg::PRICE_W +: wrsi_pkg::TIME_W];
                    n_final = s_axis_tuser[0];
                    n_state = S_EVAL;
                end
            end
            // Filter the bar, form the change and the effective period.
            S_EVAL: begin
                if (!r_final || (r_primed && (r_time <= r_last_time))) begin
                    n_state = S_IDLE;
                end else if (!r_primed) begin
                    n_primed     = 1'b1;
                    n_last_close = r_close;
                    n_last_time  = r_time;
                    n_state      = S_IDLE;
                end else begin
                    if (r_close > r_last_close) begin
                        n_gain = r_close - r_last_close;
                        n_loss = '0;
                    end else begin
                        n_gain = '0;
                        n_loss = r_last_close - r_close;
                    end
                    if (r_period == '0) begin
                        n_p = wrsi_pkg::PERIOD_MIN;
                    end else if (r_period > wrsi_pkg::PERIOD_MAX) begin
                        n_p = wrsi_pkg::PERIOD_MAX;
                    end else begin
                        n_p = r_period;
                    end
                    n_state = S_ACC;
                end
            end
            // Warm-up accumulation, or start of the smoothing divisions.
            S_ACC: begin
                if (!r_running) begin
                    n_sum_up = sum_up_x[wrsi_pkg::SUM_W] ? wrsi_pkg::SUM_MAX
                                                         : sum_up_x[wrsi_pkg::SUM_W-1:0];
                    n_sum_dn = sum_dn_x[wrsi_pkg::SUM_W] ? wrsi_pkg::SUM_MAX
                                                         : sum_dn_x[wrsi_pkg::SUM_W-1:0];
                    n_count  = count_inc;
                    n_state  = S_CHK;
                end else begin
                    n_ge_up       = g_up >= r_avg_up;
                    n_ge_dn       = g_dn >= r_avg_dn;
                    div_ctl.start = 1'b1;
                    div_ctl.steps = wrsi_pkg::WILD_STEPS;
                    div_num_up    = wrsi_pkg::t_div_num'(n_ge_up ? g_up - r_avg_up
                                                                 : r_avg_up - g_up)
                                    << (wrsi_pkg::DIV_NUM_W - wrsi_pkg::AVG_W);
                    div_num_dn    = wrsi_pkg::t_div_num'(n_ge_dn ? g_dn - r_avg_dn
                                                                 : r_avg_dn - g_dn)
                                    << (wrsi_pkg::DIV_NUM_W - wrsi_pkg::AVG_W);
                    n_state       = S_WILD;
                end
            end
            // End of warm-up: divide the sums, scaled by 2^16, by the period for Q32.16 averages.
            S_CHK: begin
                if (r_count >= r_p) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = wrsi_pkg::SEED_STEPS;
                    div_num_up    = wrsi_pkg::t_div_num'(r_sum_up)
                                    << (wrsi_pkg::DIV_NUM_W - wrsi_pkg::SUM_W);
                    div_num_dn    = wrsi_pkg::t_div_num'(r_sum_dn)
                                    << (wrsi_pkg::DIV_NUM_W - wrsi_pkg::SUM_W);
                    n_state       = S_SEED;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SEED: begin
                if (div_up_stat.done) begin
                    n_avg_up  = (div_up_quo[wrsi_pkg::DIV_NUM_W-1:wrsi_pkg::AVG_W] != '0)
                              ? wrsi_pkg::AVG_MAX : div_up_quo[wrsi_pkg::AVG_W-1:0];
                    n_avg_dn  = (div_dn_quo[wrsi_pkg::DIV_NUM_W-1:wrsi_pkg::AVG_W] != '0)
                              ? wrsi_pkg::AVG_MAX : div_dn_quo[wrsi_pkg::AVG_W-1:0];
                    n_running = 1'b1;
                    n_count   = '0;
                    n_sum_up  = '0;
                    n_sum_dn  = '0;
                    n_mul_acc = '0;
                    n_mul_cnt = 4'(wrsi_pkg::RSI_W - 1);
                    n_state   = S_MUL;
                end
            end
            // Wilder update: move towards the change by the quotient, rounding down overall.
            S_WILD: begin
                if (div_up_stat.done) begin
                    if (r_ge_up) begin
                        n_avg_up = r_avg_up + div_up_quo[wrsi_pkg::AVG_W-1:0];
                    end else begin
                        n_avg_up = r_avg_up - (div_up_quo[wrsi_pkg::AVG_W-1:0]
                                 + {{(wrsi_pkg::AVG_W-1){1'b0}}, (div_up_rem != '0)});
                    end
                    if (r_ge_dn) begin
                        n_avg_dn = r_avg_dn + div_dn_quo[wrsi_pkg::AVG_W-1:0];
                    end else begin
                        n_avg_dn = r_avg_dn - (div_dn_quo[wrsi_pkg::AVG_W-1:0]
                                 + {{(wrsi_pkg::AVG_W-1){1'b0}}, (div_dn_rem != '0)});
                    end
                    n_mul_acc = '0;
                    n_mul_cnt = 4'(wrsi_pkg::RSI_W - 1);
                    n_state   = S_MUL;
                end
            end
            // Shift-add multiply of the average gain by 10000, one constant bit a cycle.
            S_MUL: begin
                n_mul_acc = {r_mul_acc[wrsi_pkg::DIV_NUM_W-2:0], 1'b0}
                          + (wrsi_pkg::RSI_SCALE[r_mul_cnt]
                             ? wrsi_pkg::t_div_num'(r_avg_up) : '0);
                n_mul_cnt = r_mul_cnt - 1'b1;
                if (r_mul_cnt == '0) begin
                    n_state = S_RGO;
                end
            end
            // RSI quotient: the product over the sum of both averages, or full scale when no loss.
            S_RGO: begin
                if (r_avg_dn == '0) begin
                    n_rsi   = wrsi_pkg::RSI_FULL;
                    n_state = S_EMIT;
                end else begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = wrsi_pkg::RSI_STEPS;
                    div_rem       = wrsi_pkg::t_div_den'(
                                        r_mul_acc[wrsi_pkg::DIV_NUM_W-1:wrsi_pkg::RSI_W]);
                    div_den       = wrsi_pkg::t_div_den'(r_avg_up)
                                  + wrsi_pkg::t_div_den'(r_avg_dn);
                    div_num_up    = wrsi_pkg::t_div_num'(r_mul_acc[wrsi_pkg::RSI_W-1:0])
                                    << (wrsi_pkg::DIV_NUM_W - wrsi_pkg::RSI_W);
                    div_num_dn    = div_num_up;
                    n_state       = S_RDIV;
                end
            end
            S_RDIV: begin
                if (div_up_stat.done) begin
                    n_rsi   = div_up_quo[wrsi_pkg::RSI_W-1:0];
                    n_state = S_EMIT;
                end
            end
            // Hand the item to the output register once it is free.
            S_EMIT: begin
                if (emit_load) begin
                    n_out_data   = {{wrsi_pkg::OUT_PAD_W{1'b0}}, r_time, r_close,
                                    out_sum_dn, out_sum_up, out_count,
                                    out_avg_dn, out_avg_up, out_rsi};
                    n_out_user   = r_running;
                    n_out_valid  = 1'b1;
                    n_last_close = r_close;
                    n_last_time  = r_time;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and indicator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_period     <= wrsi_pkg::PERIOD_RESET;
            r_primed     <= 1'b0;
            r_running    <= 1'b0;
            r_last_close <= '0;
            r_last_time  <= '0;
            r_count      <= '0;
            r_sum_up     <= '0;
            r_sum_dn     <= '0;
            r_avg_up     <= '0;
            r_avg_dn     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_period     <= n_period;
            r_primed     <= n_primed;
            r_running    <= n_running;
            r_last_close <= n_last_close;
            r_last_time  <= n_last_time;
            r_count      <= n_count;
            r_sum_up     <= n_sum_up;
            r_sum_dn     <= n_sum_dn;
            r_avg_up     <= n_avg_up;
            r_avg_dn     <= n_avg_dn;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_close    <= n_close;
        r_time     <= n_time;
        r_final    <= n_final;
        r_gain     <= n_gain;
        r_loss     <= n_loss;
        r_p        <= n_p;
        r_ge_up    <= n_ge_up;
        r_ge_dn    <= n_ge_dn;
        r_mul_acc  <= n_mul_acc;
        r_mul_cnt  <= n_mul_cnt;
        r_rsi      <= n_rsi;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    // Two divider lanes, one for gains and one for losses.
    wrsi_div u_div_up (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_rem_init (div_rem),
        .i_num      (div_num_up),
        .i_den      (div_den),
        .o_stat     (div_up_stat),
        .o_quo      (div_up_quo),
        .o_rem      (div_up_rem)
    );

    wrsi_div u_div_dn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_rem_init (div_rem),
        .i_num      (div_num_dn),
        .i_den      (div_den),
        .o_stat     (div_dn_stat),
        .o_quo      (div_dn_quo),
        .o_rem      (div_dn_rem)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `ASSERT_PROP(a_running_sticky, i_clk, i_rst_n, r_running |=> r_running)
    `ASSERT_PROP(a_rsi_in_range, i_clk, i_rst_n,
                 (r_state == S_EMIT && r_running) |-> (r_rsi <= wrsi_pkg::RSI_FULL))
    `ASSERT_NEVER(a_lanes_in_step, i_clk, i_rst_n, div_up_stat != div_dn_stat)
    `ASSERT_PROP(a_seed_clears, i_clk, i_rst_n,
                 (r_state == S_SEED && div_up_stat.done) |=> (r_running && r_count == '0))
    `ASSERT_PROP(a_count_bounded, i_clk, i_rst_n,
                 !r_running |-> (r_count <= wrsi_pkg::PERIOD_MAX))

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Wilder RSI indicator unit testbench
// Feeds price bars with stale, unfinished and well-ordered timestamps through
// several period settings, predicts every result in a scoreboard and checks
// each result field by field while both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import wrsi_pkg::*;

    localparam int BAR_TARGET  = 540;
    localparam int PHASE_COUNT = 10;
    localparam int MAX_SHOWN   = 30;

    // Result word as it sits on m_axis_tdata, lowest field last.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [TIME_W-1:0]    stamp;
        logic [PRICE_W-1:0]   close;
        logic [SUM_W-1:0]     loss_sum;
        logic [SUM_W-1:0]     gain_sum;
        logic [COUNT_W-1:0]   warm_count;
        t_avg                 loss_avg;
        t_avg                 gain_avg;
        logic [RSI_W-1:0]     rsi;
    } t_rsi_word;

    typedef struct {
        logic      seeded;
        t_rsi_word word;
    } t_rsi_expect;

    // Predicts the indicator and holds the results still to arrive.
    class t_rsi_scoreboard;
        logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;
        bit                  primed;
        bit                  running;
        logic [PRICE_W-1:0]  last_close = '0;
        logic [TIME_W-1:0]   last_time = '0;
        logic [COUNT_W-1:0]  count_seen = '0;
        logic [SUM_W-1:0]    sum_up = '0;
        logic [SUM_W-1:0]    sum_down = '0;
        t_avg                avg_up = '0;
        t_avg                avg_down = '0;
        t_rsi_expect         rsi_due[$];
        int                  errors;
        int                  checked;

        function int pending();
            return rsi_due.size();
        endfunction

        // Period as the unit applies it: zero acts as one, large values clamp.
        function bit [63:0] window();
            if (period_reg == '0) return 64'(PERIOD_MIN);
            if (period_reg > PERIOD_MAX) return 64'(PERIOD_MAX);
            return 64'(period_reg);
        endfunction

        function bit [SUM_W-1:0] sum_sat(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
        endfunction

        // Truncated total * 2^FRAC_BITS / p, saturated to the average width.
        function bit [AVG_W-1:0] seed_average(bit [63:0] total, bit [63:0] p);
            bit [63:0] q;
            bit [63:0] r;
            bit [63:0] v;
            q = total / p;
            r = total % p;
            if (q > (64'(AVG_MAX) >> FRAC_BITS)) return AVG_MAX;
            v = (q << FRAC_BITS) + ((r << FRAC_BITS) / p);
            return (v > 64'(AVG_MAX)) ? AVG_MAX : AVG_W'(v);
        endfunction

        // Floor of (avg * (p - 1) + x * 2^FRAC_BITS) / p.
        function bit [AVG_W-1:0] wilder_step(bit [63:0] avg, bit [63:0] x, bit [63:0] p);
            bit [63:0] g;
            bit [63:0] d;
            bit [63:0] v;
            g = x << FRAC_BITS;
            if (g >= avg) begin
                v = avg + (g - avg) / p;
            end else begin
                d = avg - g;
                v = avg - (d / p + ((d % p) != 0 ? 64'd1 : 64'd0));
            end
            return (v > 64'(AVG_MAX)) ? AVG_MAX : AVG_W'(v);
        endfunction

        function bit [RSI_W-1:0] rsi_now();
            bit [63:0] r;
            if (avg_down == '0) return RSI_FULL;
            r = (64'(avg_up) * 64'(RSI_SCALE)) / (64'(avg_up) + 64'(avg_down));
            return RSI_W'(r);
        endfunction

        // Notes a bar taken by the unit and queues the result it causes.
        function void note_bar(logic [PRICE_W-1:0] close, logic [TIME_W-1:0] stamp,
                               bit closed);
            bit [63:0]   p;
            bit [63:0]   up;
            bit [63:0]   down;
            t_rsi_expect e;
            p = window();
            if (!closed) return;
            if (primed && stamp <= last_time) return;
            if (!primed) begin
                primed = 1'b1;
                last_close = close;
                last_time = stamp;
                return;
            end
            up = 0;
            down = 0;
            if (close > last_close) begin
                up = 64'(close) - 64'(last_close);
            end else begin
                down = 64'(last_close) - 64'(close);
            end
            if (!running) begin
                sum_up = sum_sat(64'(sum_up), up);
                sum_down = sum_sat(64'(sum_down), down);
                if (count_seen != COUNT_MAX) count_seen = count_seen + 1'b1;
                if (64'(count_seen) >= p) begin
                    avg_up = seed_average(64'(sum_up), p);
                    avg_down = seed_average(64'(sum_down), p);
                    running = 1'b1;
                    count_seen = '0;
                    sum_up = '0;
                    sum_down = '0;
                end
            end else begin
                avg_up = wilder_step(64'(avg_up), up, p);
                avg_down = wilder_step(64'(avg_down), down, p);
            end
            e.seeded = running;
            e.word = '0;
            if (running) begin
                e.word.rsi = rsi_now();
                e.word.gain_avg = avg_up;
                e.word.loss_avg = avg_down;
            end else begin
                e.word.warm_count = count_seen;
                e.word.gain_sum = sum_up;
                e.word.loss_sum = sum_down;
            end
            e.word.close = close;
            e.word.stamp = stamp;
            rsi_due.push_back(e);
            last_close = close;
            last_time = stamp;
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        // Compares one result from the unit with the oldest prediction.
        function void check_result(logic seeded, logic [M_TDATA_W-1:0] data);
            t_rsi_word   got;
            t_rsi_expect e;
            got = t_rsi_word'(data);
            if (rsi_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, data);
                return;
            end
            e = rsi_due.pop_front();
            checked++;
            field_check("seeded", 64'(e.seeded), 64'(seeded));
            field_check("rsi_hundredths", 64'(e.word.rsi), 64'(got.rsi));
            field_check("average_gain", 64'(e.word.gain_avg), 64'(got.gain_avg));
            field_check("average_loss", 64'(e.word.loss_avg), 64'(got.loss_avg));
            field_check("warmup_done", 64'(e.word.warm_count), 64'(got.warm_count));
            field_check("gain_total", 64'(e.word.gain_sum), 64'(got.gain_sum));
            field_check("loss_total", 64'(e.word.loss_sum), 64'(got.loss_sum));
            field_check("close_echo", 64'(e.word.close), 64'(got.close));
            field_check("time_echo", 64'(e.word.stamp), 64'(got.stamp));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [PERIOD_W-1:0]    i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    t_rsi_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              bars_used;
    int              bars_sent;
    int              up_bias;
    int unsigned     walk_span;

    wilder_rsi_indicator_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // close_price, start_time, pad
        .s_axis_tuser  (s_axis_tuser),   // is_final
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // rsi, averages, warm-up count and sums, echo
        .m_axis_tuser  (m_axis_tuser)    // seeded
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: check each accepted item, then choose the next ready value.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stall pattern follows how far the random bars have got.
    function void set_idle();
        case (bars_used * 3 / BAR_TARGET)
            0: begin
                send_idle_pct = 6;
                recv_idle_pct = 57;
            end
            1: begin
                send_idle_pct = 57;
                recv_idle_pct = 6;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // Offers one bar after idling in a random share of cycles, and waits for it to be taken.
    task automatic send_bar(logic [PRICE_W-1:0] close, logic [TIME_W-1:0] stamp, bit closed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_TDATA_W'({stamp, close});
        s_axis_tuser <= closed;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_bar(close, stamp, closed);
        bars_sent++;
    endtask

    // Writes the period once the unit has drained and gone quiet.
    task automatic write_period(logic [PERIOD_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.period_reg = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Next close: mostly a biased walk, with jumps, extremes and flat bars.
    function logic [PRICE_W-1:0] next_close();
        logic [PRICE_W-1:0] base;
        int unsigned        delta;
        int                 r;
        base = sb.last_close;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) up_bias = $urandom_range(0, 2) * 45 + 5;
        if (r < 10) return $urandom;
        if (r < 15) return $urandom_range(0, 1) ? '1 : '0;
        if (r < 20) return base;
        delta = $urandom_range(0, walk_span);
        if ($urandom_range(0, 99) < up_bias)
            return (base > PRICE_W'('1) - delta) ? '1 : base + delta;
        return (base < delta) ? '0 : base - delta;
    endfunction

    // One random bar: noise, a stale bar or a newer final bar.
    task automatic random_bar();
        logic [PRICE_W-1:0] close;
        logic [TIME_W-1:0]  stamp;
        bit [63:0]          step;
        int                 roll;
        int                 k;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            close = $urandom;
            stamp = TIME_W'({$urandom, $urandom});
            send_bar(close, stamp, 1'b0);
        end else if (roll < 15) begin
            close = $urandom;
            step = {$urandom, $urandom};
            if (roll < 11)
                stamp = sb.last_time;
            else
                stamp = sb.last_time - TIME_W'(step % (64'(sb.last_time) + 1));
            send_bar(close, stamp, 1'b1);
        end else begin
            k = $urandom_range(0, 99);
            if (k < 5)
                step = 64'($urandom);
            else if (k < 7)
                step = {16'h0, 16'($urandom_range(0, 65535)), 32'($urandom)};
            else
                step = 64'($urandom_range(0, 19));
            close = next_close();
            stamp = sb.last_time + TIME_W'(step + 1);
            bars_used++;
            send_bar(close, stamp, 1'b1);
        end
    endtask

    // Main sequence.
    initial begin
        int unsigned periods[PHASE_COUNT];
        int          goal;
        sb = new();
        periods = '{2047, 2, 1024, 0, 14, 1025, 3, 1, 0, 2047};
        periods[8] = $urandom_range(4, 300);
        bars_used = 0;
        bars_sent = 0;
        set_idle();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Warm-up at the reset period: unfinished, first, stale and equal-time bars,
        // largest rise and fall, flat change.
        send_bar('1, '1, 1'b0);
        send_bar(32'd1000, 63'd5, 1'b1);
        send_bar(32'd77, 63'd5, 1'b1);
        send_bar(32'd77, 63'd3, 1'b1);
        send_bar('1, 63'd6, 1'b1);
        send_bar('0, 63'd7, 1'b1);
        send_bar('0, 63'd8, 1'b1);
        send_bar(32'd100, 63'd9, 1'b1);
        send_bar(32'd5, 63'd10, 1'b0);
        send_bar(32'd50, 63'd1000, 1'b1);
        // Out-of-range period keeps the warm-up going.
        write_period('1);
        send_bar(32'd60, 63'd1001, 1'b1);
        send_bar(32'd40, 63'd1002, 1'b1);
        send_bar(32'd40, 63'd1003, 1'b1);
        // A period the count has just reached seeds the averages.
        write_period(11'd9);
        send_bar(32'd2000000000, 63'd1010, 1'b1);
        send_bar(32'd2000000005, 63'd1011, 1'b1);
        send_bar(32'd1900000000, 63'd1012, 1'b1);
        send_bar('1, 63'd1013, 1'b1);
        // Zero period: a pure fall gives RSI zero, then no loss gives full scale.
        write_period('0);
        send_bar(32'd100, 63'd1020, 1'b1);
        send_bar(32'd200, 63'd1021, 1'b1);
        send_bar(32'd200, 63'd1022, 1'b1);
        write_period(11'd1);
        send_bar('0, 63'd1023, 1'b1);
        send_bar(32'd5, 63'd1024, 1'b1);

        // Random phases, one period setting each.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            write_period(PERIOD_W'(periods[ph]));
            up_bias = $urandom_range(0, 2) * 45 + 5;
            case ($urandom_range(0, 2))
                0: walk_span = 15;
                1: walk_span = 1000;
                default: walk_span = 1 << 20;
            endcase
            goal = (ph + 1) * BAR_TARGET / PHASE_COUNT;
            while (bars_used < goal) begin
                set_idle();
                random_bar();
            end
        end

        // Latest possible start time, then the same time again as a stale bar.
        send_bar($urandom, '1, 1'b1);
        send_bar('0, '1, 1'b1);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d bars, %0d results checked against the prediction.",
                 bars_sent, sb.checked);
        $display("Periods covered 14 from reset, 0, 1, 2, 3, 9, 1024, 1025, 2047 and one random.");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
